[hdl/rsf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_pkg: shared types and constants for the receive slot FIFO
// Slot geometry, opcode and status codes, and the controller/datapath bundles.
// ----------------------------------------------------------------------------
package rsf_pkg;

   localparam int NUM_SLOTS = 16;
   localparam int SLOT_LEN  = 70;
   localparam int PLAYERS   = 5;

   localparam int STRIDE    = SLOT_LEN / PLAYERS;
   localparam int DEPTH     = NUM_SLOTS * SLOT_LEN;
   localparam int ADDR_W    = $clog2(DEPTH);
   localparam int OFF_W     = $clog2(SLOT_LEN);
   localparam int CNT_W     = $clog2(NUM_SLOTS + 1);

   typedef enum logic [1:0] {
      OP_WRITE = 2'd0,
      OP_READ  = 2'd1,
      OP_CLEAR = 2'd2
   } opcode_type;

   typedef enum logic [2:0] {
      ST_TAKEN     = 3'd0,
      ST_COMMITTED = 3'd1,
      ST_DROPPED   = 3'd2,
      ST_REFUSED   = 3'd3,
      ST_READ_OK   = 3'd4,
      ST_READ_FAIL = 3'd5,
      ST_CLEARED   = 3'd6
   } status_type;

   // controller -> datapath
   typedef struct packed {
      logic exec;     // beat accepted this cycle
      logic capture;  // RAM read data valid, load it into the response
   } dp_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic needs_read;  // current request is a read that will succeed
   } dp_stat_type;

   // Players whose leading byte pair covers this write offset.
   function automatic logic [PLAYERS-1:0] player_hits(input logic [OFF_W-1:0] off);
      logic [PLAYERS-1:0] hits;
      hits = '0;
      for (int p = 0; p < PLAYERS; p++) begin
         if (int'(off) == p * STRIDE || int'(off) == p * STRIDE + 1) begin
            hits[p] = 1'b1;
         end
      end
      return hits;
   endfunction

endpackage
`default_nettype wire

[hdl/rsf_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_ram: generic single-port RAM
// One access per cycle, write or read, read data registered.
// ----------------------------------------------------------------------------
module rsf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wdata,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule
`default_nettype wire

[hdl/rsf_ctrl.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_ctrl: handshake controller
// Accepts request beats, waits out the RAM read latency, owns response valid.
// ----------------------------------------------------------------------------
module rsf_ctrl (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   input  wire rsf_pkg::dp_stat_type stat,
   output rsf_pkg::dp_cmd_type       cmd
);
   import rsf_pkg::*;

   typedef enum logic {
      IDLE,
      RD_WAIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      accept;

   // accept only when no RAM read is outstanding and the response register is free or being emptied this cycle
   assign req_stall = (state_ff == RD_WAIT) || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign cmd.exec    = accept;
   assign cmd.capture = (state_ff == RD_WAIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            IDLE: begin
               if (accept && stat.needs_read) begin
                  state_ff     <= RD_WAIT;
                  rsp_valid_ff <= 1'b0;
               end else if (accept) begin
                  rsp_valid_ff <= 1'b1;
               end else if (rsp_valid_ff && !rsp_stall) begin
                  rsp_valid_ff <= 1'b0;
               end
            end
            RD_WAIT: begin
               state_ff     <= IDLE;
               rsp_valid_ff <= 1'b1;
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule
`default_nettype wire

[hdl/rsf_datapath.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rsf_datapath: slot store, ring pointers and response registers
// Executes one opcode per accepted beat; read data is captured from the RAM in the RD_WAIT state.
// ----------------------------------------------------------------------------
module rsf_datapath (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire rsf_pkg::dp_cmd_type cmd,
   output rsf_pkg::dp_stat_type     stat,
   input  wire logic [1:0]          req_opcode,
   input  wire logic [7:0]          req_data_byte,
   output logic      [7:0]          rsp_read_byte,
   output logic                     rsp_read_last,
   output logic      [2:0]          rsp_status,
   output logic      [4:0]          rsp_queue_count,
   output logic                     rsp_full_flag
);
   import rsf_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_BASE = ADDR_W'((NUM_SLOTS - 1) * SLOT_LEN);
   localparam logic [ADDR_W-1:0] SLOT_STEP = ADDR_W'(SLOT_LEN);
   localparam logic [OFF_W-1:0]  LAST_OFF  = OFF_W'(SLOT_LEN - 1);
   localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(NUM_SLOTS);
   localparam logic [PLAYERS-1:0] ALL_EMPTY = '1;

   // control state
   logic [ADDR_W-1:0]  wbase_ff, wbase_in;
   logic [ADDR_W-1:0]  rbase_ff, rbase_in;
   logic [OFF_W-1:0]   woff_ff, woff_in;
   logic [OFF_W-1:0]   roff_ff, roff_in;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               flag_ff, flag_in;
   logic [PLAYERS-1:0] empty_ff, empty_in;
   logic               refusing_ff, refusing_in;

   // response payload
   logic [7:0]         rbyte_ff;
   logic               rlast_ff, rlast_in;
   status_type         status_ff, status_in;

   // RAM port
   logic               ram_we;
   logic [ADDR_W-1:0]  ram_addr;
   logic [7:0]         ram_rdata;

   logic               slot_start;
   logic               refuse_now;
   logic [PLAYERS-1:0] empty_now;
   logic               read_ok;

   assign read_ok         = (count_ff != '0) && !flag_ff;
   assign stat.needs_read = (req_opcode == OP_READ) && read_ok;

   assign slot_start = (woff_ff == '0);
   assign refuse_now = slot_start ? (count_ff >= CNT_FULL) : refusing_ff;

   always_comb begin
      empty_now = slot_start ? ALL_EMPTY : empty_ff;
      if (!refuse_now && req_data_byte != 8'd0) begin
         empty_now = empty_now & ~player_hits(woff_ff);
      end
   end

   always_comb begin
      wbase_in    = wbase_ff;
      rbase_in    = rbase_ff;
      woff_in     = woff_ff;
      roff_in     = roff_ff;
      count_in    = count_ff;
      flag_in     = flag_ff;
      empty_in    = empty_ff;
      refusing_in = refusing_ff;
      rlast_in    = 1'b0;
      status_in   = ST_READ_FAIL;
      ram_we      = 1'b0;
      ram_addr    = rbase_ff + ADDR_W'(roff_ff);

      case (req_opcode)
         OP_WRITE: begin
            ram_addr  = wbase_ff + ADDR_W'(woff_ff);
            ram_we    = cmd.exec && !refuse_now;
            flag_in   = flag_ff || (slot_start && refuse_now);
            status_in = refuse_now ? ST_REFUSED : ST_TAKEN;
            if (woff_ff == LAST_OFF) begin
               if (!refuse_now) begin
                  if (empty_now == ALL_EMPTY) begin
                     status_in = ST_DROPPED;
                  end else begin
                     status_in = ST_COMMITTED;
                     wbase_in  = (wbase_ff == LAST_BASE) ? '0 : wbase_ff + SLOT_STEP;
                     count_in  = count_ff + 1'b1;
                  end
               end
               woff_in     = '0;
               refusing_in = 1'b0;
               empty_in    = ALL_EMPTY;
            end else begin
               woff_in     = woff_ff + 1'b1;
               refusing_in = refuse_now;
               empty_in    = empty_now;
            end
         end
         OP_READ: begin
            if (read_ok) begin
               status_in = ST_READ_OK;
               if (roff_ff == LAST_OFF) begin
                  rlast_in = 1'b1;
                  roff_in  = '0;
                  rbase_in = (rbase_ff == LAST_BASE) ? '0 : rbase_ff + SLOT_STEP;
                  count_in = count_ff - 1'b1;
               end else begin
                  roff_in = roff_ff + 1'b1;
               end
            end
         end
         OP_CLEAR: begin
            wbase_in    = '0;
            rbase_in    = '0;
            woff_in     = '0;
            roff_in     = '0;
            count_in    = '0;
            flag_in     = 1'b0;
            empty_in    = ALL_EMPTY;
            refusing_in = 1'b0;
            status_in   = ST_CLEARED;
         end
         default: begin
            status_in = ST_READ_FAIL;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wbase_ff    <= '0;
         rbase_ff    <= '0;
         woff_ff     <= '0;
         roff_ff     <= '0;
         count_ff    <= '0;
         flag_ff     <= 1'b0;
         empty_ff    <= ALL_EMPTY;
         refusing_ff <= 1'b0;
      end else if (cmd.exec) begin
         wbase_ff    <= wbase_in;
         rbase_ff    <= rbase_in;
         woff_ff     <= woff_in;
         roff_ff     <= roff_in;
         count_ff    <= count_in;
         flag_ff     <= flag_in;
         empty_ff    <= empty_in;
         refusing_ff <= refusing_in;
      end
   end

   // payload captured at accept; the byte of a good read is loaded from the RAM in the RD_WAIT state
   always_ff @(posedge clock) begin
      if (cmd.exec) begin
         rbyte_ff  <= 8'd0;
         rlast_ff  <= rlast_in;
         status_ff <= status_in;
      end else if (cmd.capture) begin
         rbyte_ff <= ram_rdata;
      end
   end

   rsf_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_store (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (req_data_byte),
      .rdata (ram_rdata)
   );

   assign rsp_read_byte   = rbyte_ff;
   assign rsp_read_last   = rlast_ff;
   assign rsp_status      = status_ff;
   assign rsp_queue_count = 5'(count_ff);
   assign rsp_full_flag   = flag_ff;

endmodule
`default_nettype wire

[hdl/receive_slot_fifo_drop_empty_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// receive_slot_fifo_drop_empty_core: ring FIFO of fixed-length receive slots
// Slots are written and read one byte per request beat; empty slots dropped.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_*): one beat carries an opcode (write byte, read byte,
//   clear) and a data byte. Response channel (rsp_*): exactly one beat per
//   request, in order, with read byte, end-of-slot mark, status, slot count
//   and the sticky full flag.
//   Timing: write, clear and failed read answer on the cycle after accept;
//   a successful read first passes the RD_WAIT state, which captures the
//   registered read of the single-port slot RAM. Writes, clears and failed
//   reads take one beat per cycle unless rsp_stall holds the response; after
//   a successful read the controller holds off the next request in RD_WAIT.
//   A new request is taken while the response register is being emptied.
//   Reset (synchronous) empties the queue and clears the full flag; stored
//   bytes are not cleared. While rsp_stall is high the response holds and
//   req_stall rises, so no request is lost.
// ----------------------------------------------------------------------------
module receive_slot_fifo_drop_empty_core (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output logic            req_stall,
   input  wire logic [1:0] req_opcode,
   input  wire logic [7:0] req_data_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_stall,
   output logic      [7:0] rsp_read_byte,
   output logic            rsp_read_last,
   output logic      [2:0] rsp_status,
   output logic      [4:0] rsp_queue_count,
   output logic            rsp_full_flag
);
   import rsf_pkg::*;

   dp_cmd_type  cmd;
   dp_stat_type stat;

   rsf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   rsf_datapath u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .stat            (stat),
      .req_opcode      (req_opcode),
      .req_data_byte   (req_data_byte),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_read_last   (rsp_read_last),
      .rsp_status      (rsp_status),
      .rsp_queue_count (rsp_queue_count),
      .rsp_full_flag   (rsp_full_flag)
   );

   // good read: response withheld and requests stalled while RAM data is captured, then shown
   a_read_latency: assert property (@(posedge clock) disable iff (reset)
      cmd.exec && stat.needs_read |=> !rsp_valid && req_stall ##1 rsp_valid)
      else $error("read response timing broken");

   a_last_only_on_read: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_read_last |-> rsp_status == ST_READ_OK)
      else $error("end-of-slot mark on non-read response");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_READ_OK |-> rsp_read_byte == 8'd0 && !rsp_read_last)
      else $error("non-read response carries data");

   a_no_accept_in_wait: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |-> !cmd.exec)
      else $error("request accepted while RAM read outstanding");

endmodule
`default_nettype wire

[dv/slot_fifo_score_pkg.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slot_fifo_score_pkg: expected-reply tracking for the receive slot FIFO
// Mirrors the slot ring, offsets, count and full flag of the core, works out
// the reply to every request beat and checks replies in order.
// ----------------------------------------------------------------------------
package slot_fifo_score_pkg;
   import rsf_pkg::*;

   localparam int SLOT_W = $clog2(NUM_SLOTS);

   typedef struct packed {
      logic [7:0] read_byte;
      logic       read_last;
      status_type status;
      logic [4:0] queue_count;
      logic       full_flag;
   } slot_reply_type;

   class slot_fifo_scoreboard;
      logic [7:0]         slot_bytes [DEPTH];
      logic [SLOT_W-1:0]  wr_slot;
      logic [SLOT_W-1:0]  rd_slot;
      logic [CNT_W-1:0]   held_slots;
      logic               overflow;
      logic [OFF_W-1:0]   wr_off;
      logic [OFF_W-1:0]   rd_off;
      logic [PLAYERS-1:0] quiet_players;
      logic               refusing;
      slot_reply_type     due_replies [$];
      int                 errors;
      int                 checked;

      function new();
         errors  = 0;
         checked = 0;
         clear_queue_state();
      endfunction

      function void clear_queue_state();
         wr_slot       = '0;
         rd_slot       = '0;
         held_slots    = '0;
         overflow      = 1'b0;
         wr_off        = '0;
         rd_off        = '0;
         quiet_players = '1;
         refusing      = 1'b0;
      endfunction

      function int pending();
         return due_replies.size();
      endfunction

      function status_type store_write_byte(logic [7:0] value);
         status_type st;
         st = ST_TAKEN;
         if (wr_off == 0) begin
            quiet_players = '1;
            refusing = (held_slots >= NUM_SLOTS);
            if (refusing) begin
               overflow = 1'b1;
            end
         end
         if (refusing) begin
            st = ST_REFUSED;
         end else begin
            slot_bytes[int'(wr_slot) * SLOT_LEN + int'(wr_off)] = value;
            if (value != 8'd0) begin
               for (int p = 0; p < PLAYERS; p++) begin
                  if (int'(wr_off) == p * STRIDE || int'(wr_off) == p * STRIDE + 1) begin
                     quiet_players[p] = 1'b0;
                  end
               end
            end
         end
         if (wr_off >= SLOT_LEN - 1) begin
            if (!refusing) begin
               // a slot whose every player pair is zero never enters the ring
               if (&quiet_players) begin
                  st = ST_DROPPED;
               end else begin
                  wr_slot    = (wr_slot == NUM_SLOTS - 1) ? '0 : wr_slot + 1'b1;
                  held_slots = held_slots + 1'b1;
                  st         = ST_COMMITTED;
               end
            end
            wr_off        = '0;
            refusing      = 1'b0;
            quiet_players = '1;
         end else begin
            wr_off = wr_off + 1'b1;
         end
         return st;
      endfunction

      // Called once per accepted request beat.
      function void predict_reply(logic [1:0] op, logic [7:0] value);
         slot_reply_type r;
         r = '0;
         case (op)
            OP_WRITE: begin
               r.status = store_write_byte(value);
            end
            OP_READ: begin
               if (held_slots == 0 || overflow) begin
                  r.status = ST_READ_FAIL;
               end else begin
                  r.read_byte = slot_bytes[int'(rd_slot) * SLOT_LEN + int'(rd_off)];
                  r.status    = ST_READ_OK;
                  if (rd_off >= SLOT_LEN - 1) begin
                     r.read_last = 1'b1;
                     rd_off      = '0;
                     rd_slot     = (rd_slot == NUM_SLOTS - 1) ? '0 : rd_slot + 1'b1;
                     held_slots  = held_slots - 1'b1;
                  end else begin
                     rd_off = rd_off + 1'b1;
                  end
               end
            end
            OP_CLEAR: begin
               clear_queue_state();
               r.status = ST_CLEARED;
            end
            default: begin
               r.status = ST_READ_FAIL;
            end
         endcase
         r.queue_count = held_slots;
         r.full_flag   = overflow;
         due_replies.push_back(r);
      endfunction

      task report(string msg);
         if (errors < 200) begin
            $display("%0t mismatch: %s", $time, msg);
         end
         errors++;
      endtask

      task check_reply(slot_reply_type got);
         slot_reply_type exp;
         if (due_replies.size() == 0) begin
            report($sformatf("response beat with no request outstanding, status %0d",
                             got.status));
            return;
         end
         exp = due_replies.pop_front();
         checked++;
         if (got.read_byte !== exp.read_byte)
            report($sformatf("reply %0d read_byte %0d, want %0d",
                             checked, got.read_byte, exp.read_byte));
         if (got.read_last !== exp.read_last)
            report($sformatf("reply %0d read_last %0d, want %0d",
                             checked, got.read_last, exp.read_last));
         if (got.status !== exp.status)
            report($sformatf("reply %0d status %0d, want %0d",
                             checked, got.status, exp.status));
         if (got.queue_count !== exp.queue_count)
            report($sformatf("reply %0d queue_count %0d, want %0d",
                             checked, got.queue_count, exp.queue_count));
         if (got.full_flag !== exp.full_flag)
            report($sformatf("reply %0d full_flag %0d, want %0d",
                             checked, got.full_flag, exp.full_flag));
      endtask
   endclass

endpackage

[dv/receive_slot_fifo_drop_empty_core_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// receive_slot_fifo_drop_empty_core_test: self-checking bench for the core
// Drives byte writes, reads, clears and stray opcodes with random gaps and
// response stalls, fills the ring to overflow, and checks every reply beat.
// ----------------------------------------------------------------------------
module receive_slot_fifo_drop_empty_core_test;
   import rsf_pkg::*;
   import slot_fifo_score_pkg::*;

   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int TOTAL_ITEMS = 1450;
   localparam int PAUSE_AT    = 350;
   localparam int FILL_AT     = 150;
   localparam int QUIET_FROM  = 800;
   localparam int QUIET_TO    = 1100;
   localparam int HOLD_AT     = 150;
   localparam int HOLD_CYCLES = 120;
   localparam int IDLE_PCT    = 11;
   localparam int STUCK_LIMIT = 5000;

   typedef enum int {
      FILL_RANDOM,
      FILL_QUIET,
      FILL_ONE_LOUD,
      FILL_ZERO,
      FILL_ONES
   } slot_fill_mode_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [1:0] req_opcode = 2'd0;
   logic [7:0] req_data_byte = 8'd0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_read_byte;
   logic       rsp_read_last;
   logic [2:0] rsp_status;
   logic [4:0] rsp_queue_count;
   logic       rsp_full_flag;

   slot_fifo_scoreboard sb = new();
   int sent = 0;

   always #1 clock = ~clock;

   receive_slot_fifo_drop_empty_core u_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_data_byte   (req_data_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_read_byte   (rsp_read_byte),
      .rsp_read_last   (rsp_read_last),
      .rsp_status      (rsp_status),
      .rsp_queue_count (rsp_queue_count),
      .rsp_full_flag   (rsp_full_flag)
   );

   task automatic send_item(input logic [1:0] op, input logic [7:0] value);
      while (!(sent >= QUIET_FROM && sent < QUIET_TO) && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_opcode    <= op;
      req_data_byte <= value;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.predict_reply(op, value);
      sent++;
   endtask

   // One whole slot of write beats; the mode shapes the player pair bytes.
   task automatic write_slot(input slot_fill_mode_type mode);
      int loud_pos;
      logic [7:0] b;
      bit pair;
      loud_pos = $urandom_range(0, PLAYERS - 1) * STRIDE + $urandom_range(0, 1);
      for (int i = 0; i < SLOT_LEN; i++) begin
         pair = (i % STRIDE) < 2 && (i / STRIDE) < PLAYERS;
         b = 8'($urandom_range(0, 255));
         case (mode)
            FILL_QUIET: begin
               if (pair) b = 8'd0;
            end
            FILL_ONE_LOUD: begin
               if (i == loud_pos) b = 8'($urandom_range(1, 255));
               else if (pair) b = 8'd0;
            end
            FILL_ZERO: b = 8'd0;
            FILL_ONES: b = 8'hFF;
            default: ;
         endcase
         send_item(OP_WRITE, b);
      end
   endtask

   // Sender
   initial begin
      int roll;
      int n;
      int pick;
      bit paused;
      bit filled;
      slot_fill_mode_type mode;
      paused = 1'b0;
      filled = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed opening: empty read, stray opcode, clears, byte extremes
      send_item(OP_READ, 8'hFF);
      send_item(OP_UNUSED, 8'hFF);
      send_item(OP_CLEAR, 8'h00);
      send_item(OP_WRITE, 8'hFF);
      send_item(OP_WRITE, 8'h00);
      send_item(OP_WRITE, 8'h5A);
      send_item(OP_READ, 8'h00);
      send_item(OP_CLEAR, 8'hA5);   // abandons the partial slot
      send_item(OP_WRITE, 8'h00);
      send_item(OP_UNUSED, 8'h00);
      send_item(OP_CLEAR, 8'hFF);

      while (sent < TOTAL_ITEMS) begin
         if (!paused && sent >= PAUSE_AT) begin
            paused = 1'b1;
            req_valid <= 1'b0;
            while (sb.pending() != 0) @(posedge clock);
         end
         if (!filled && sent >= FILL_AT) begin
            // run the ring to overflow with slots that commit; the last one is
            // refused, then reads fail until the clear recovers
            filled = 1'b1;
            while (!sb.overflow) begin
               pick = $urandom_range(0, 2);
               mode = (pick == 0) ? FILL_RANDOM : (pick == 1) ? FILL_ONE_LOUD : FILL_ONES;
               write_slot(mode);
            end
            repeat (3) send_item(OP_READ, 8'($urandom_range(0, 255)));
            send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
         end else begin
            roll = $urandom_range(99);
            if (roll < 45) begin
               write_slot(slot_fill_mode_type'($urandom_range(0, 4)));
            end else if (roll < 80) begin
               n = $urandom_range(0, 1) ? SLOT_LEN : $urandom_range(1, 2 * SLOT_LEN);
               repeat (n) send_item(OP_READ, 8'($urandom_range(0, 255)));
            end else if (roll < 83) begin
               send_item(OP_CLEAR, 8'($urandom_range(0, 255)));
            end else begin
               n = $urandom_range(1, 6);
               repeat (n) send_item(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
            end
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

   // Receiver: checks reply beats, random stalls, one long hold-off
   initial begin
      slot_reply_type seen;
      int hold_left;
      bit held;
      hold_left = 0;
      held = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            seen.read_byte   = rsp_read_byte;
            seen.read_last   = rsp_read_last;
            seen.status      = status_type'(rsp_status);
            seen.queue_count = rsp_queue_count;
            seen.full_flag   = rsp_full_flag;
            sb.check_reply(seen);
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else if (!held && sb.checked >= HOLD_AT) begin
            held = 1'b1;
            hold_left = HOLD_CYCLES - 1;
            rsp_stall <= 1'b1;
         end else if (sb.checked >= QUIET_FROM && sb.checked < QUIET_TO) begin
            rsp_stall <= 1'b0;
         end else begin
            rsp_stall <= ($urandom_range(99) < IDLE_PCT);
         end
      end
   end

   // Watchdog: too long without any beat on either channel
   initial begin
      int stuck;
      stuck = 0;
      while (stuck < STUCK_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) stuck = 0;
         else stuck++;
      end
      $display("== FAIL ==");
      $finish;
   end

endmodule
